[rtl/atrd_pkg.sv]
// Shared types and constants of the allocation trace record decoder.
// No dependencies; every other file of the block but atrd_ram imports it.
package atrd_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned GROUP_W       = 7;
  localparam int unsigned DELTA_W       = 28;
  localparam int unsigned SIZE_W        = 28;
  localparam int unsigned TAG_W         = 32;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned ERR_W         = 3;
  localparam int unsigned TAG_COUNT_DEF = 65536;
  // Queue depth between front and back; keep a power of two.
  localparam int unsigned Q_DEPTH       = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_REALLOC = 2'd1,
    OP_FREE    = 2'd2,
    OP_END     = 2'd3
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE           = 3'd0,
    ERR_UNTERMINATED   = 3'd1,
    ERR_TRUNCATED      = 3'd2,
    ERR_OLD_TOO_FAR    = 3'd3,
    ERR_FREE_WITH_SIZE = 3'd4,
    ERR_TAG_OVERFLOW   = 3'd5,
    ERR_TAG_IN_USE     = 3'd6,
    ERR_TAG_NOT_IN_USE = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    EK_RECORD = 2'd0,
    EK_END    = 2'd1,
    EK_ERROR  = 2'd2
  } entry_kind_e;

  typedef enum logic [1:0] {
    FP_SIZE = 2'd0,
    FP_OLD  = 2'd1,
    FP_NEW  = 2'd2
  } field_pos_e;

  typedef enum logic [1:0] {
    BS_CLEAR = 2'd0,
    BS_RUN   = 2'd1,
    BS_CHECK = 2'd2,
    BS_HALT  = 2'd3
  } back_state_e;

  // One classified item handed from the front to the back.
  typedef struct packed {
    entry_kind_e             kind;
    err_e                    code;
    logic [SIZE_W-1:0]       size;
    logic [DELTA_W-1:0]      old_delta;
    logic [DELTA_W-1:0]      new_delta;
  } entry_t;

  // Back status seen by the front.
  typedef struct packed {
    logic clearing;
    logic halted;
  } back_status_t;

endpackage

[rtl/atrd_ram.sv]
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module atrd_ram #(
  parameter int unsigned WIDTH  = 1,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr0_i,
  input  logic [ADDR_W-1:0] rd_addr1_i,
  output logic [WIDTH-1:0]  rd_data0_o,
  output logic [WIDTH-1:0]  rd_data1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data0_q;
  logic [WIDTH-1:0] rd_data1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data0_q <= mem_q[rd_addr0_i];
      rd_data1_q <= mem_q[rd_addr1_i];
    end
  end

  assign rd_data0_o = rd_data0_q;
  assign rd_data1_o = rd_data1_q;

endmodule

[rtl/atrd_front.sv]
// Front of the decoder: varint parsing and record assembly.
// Depends on atrd_pkg; pushes classified items into atrd_queue.
module atrd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [atrd_pkg::BYTE_W-1:0]   byte_value_i,
  input  logic                          q_full_i,
  input  atrd_pkg::back_status_t        status_i,
  output logic                          push_o,
  output atrd_pkg::entry_t              entry_o
);
  import atrd_pkg::*;

  field_pos_e         pos_q, pos_d;
  logic [1:0]         gc_q, gc_d;
  logic [DELTA_W-1:0] acc_q, acc_d;
  logic [SIZE_W-1:0]  hsize_q, hsize_d;
  logic [DELTA_W-1:0] hold_q, hold_d;
  logic               halt_q, halt_d;

  logic               accept;
  logic [DELTA_W-1:0] acc_next;

  assign in_stall_o = status_i.clearing | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign acc_next   = acc_q | (DELTA_W'(byte_value_i[GROUP_W-1:0]) << (GROUP_W * gc_q));

  always_comb begin
    pos_d   = pos_q;
    gc_d    = gc_q;
    acc_d   = acc_q;
    hsize_d = hsize_q;
    hold_d  = hold_q;
    halt_d  = halt_q;
    push_o  = 1'b0;
    entry_o = '{kind: EK_RECORD, code: ERR_NONE, size: '0, old_delta: '0, new_delta: '0};
    if (accept && !halt_q && !status_i.halted) begin
      if (kind_i) begin
        push_o = 1'b1;
        if (pos_q == FP_SIZE && gc_q == 2'd0) begin
          entry_o.kind = EK_END;
        end else begin
          entry_o.kind = EK_ERROR;
          entry_o.code = ERR_TRUNCATED;
          halt_d       = 1'b1;
        end
      end else if (!byte_value_i[BYTE_W-1]) begin
        if (gc_q == 2'd3) begin
          push_o       = 1'b1;
          entry_o.kind = EK_ERROR;
          entry_o.code = ERR_UNTERMINATED;
          halt_d       = 1'b1;
        end else begin
          gc_d  = gc_q + 2'd1;
          acc_d = acc_next;
        end
      end else begin
        acc_d = '0;
        gc_d  = 2'd0;
        case (pos_q)
          FP_SIZE: begin
            hsize_d = acc_next;
            pos_d   = FP_OLD;
          end
          FP_OLD: begin
            if (hsize_q != '0) begin
              hold_d = acc_next;
              pos_d  = FP_NEW;
            end else begin
              push_o            = 1'b1;
              entry_o.old_delta = acc_next;
              pos_d             = FP_SIZE;
            end
          end
          FP_NEW: begin
            push_o            = 1'b1;
            entry_o.size      = hsize_q;
            entry_o.old_delta = hold_q;
            entry_o.new_delta = acc_next;
            pos_d             = FP_SIZE;
          end
          default: begin
            pos_d = FP_SIZE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= FP_SIZE;
      gc_q    <= 2'd0;
      acc_q   <= '0;
      hsize_q <= '0;
      hold_q  <= '0;
      halt_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      gc_q    <= gc_d;
      acc_q   <= acc_d;
      hsize_q <= hsize_d;
      hold_q  <= hold_d;
      halt_q  <= halt_d;
    end
  end

endmodule

[rtl/atrd_queue.sv]
// Short queue of classified items between front and back.
// Depends on atrd_pkg.
module atrd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  atrd_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output atrd_pkg::entry_t head_o
);
  import atrd_pkg::*;

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  entry_t           slot_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

[rtl/atrd_back.sv]
// Back of the decoder: tag resolution, in-use map checks, result register.
// Depends on atrd_pkg and atrd_ram; takes items from atrd_queue.
module atrd_back #(
  parameter int unsigned TAG_COUNT = atrd_pkg::TAG_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  atrd_pkg::entry_t            head_i,
  output logic                        pop_o,
  output atrd_pkg::back_status_t      status_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [atrd_pkg::OP_W-1:0]   op_o,
  output logic [atrd_pkg::ERR_W-1:0]  error_o,
  output logic [atrd_pkg::SIZE_W-1:0] size_o,
  output logic [atrd_pkg::TAG_W-1:0]  old_tag_o,
  output logic [atrd_pkg::TAG_W-1:0]  new_tag_o
);
  import atrd_pkg::*;

  localparam int unsigned AW    = $clog2(TAG_COUNT);
  localparam int unsigned SUM_W = ((DELTA_W > AW) ? DELTA_W : AW) + 1;

  back_state_e       state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     lnt_q, lnt_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;

  // Record held between the read and check cycles.
  logic [SIZE_W-1:0] rsize_q;
  logic [AW-1:0]     old_addr_q, new_addr_q;
  logic              is_old_q, is_new_q, err3_q, oor_q;
  logic              byp_en_q, byp_data_q;
  logic [AW-1:0]     byp_addr_q;

  logic              out_valid_q, out_valid_d;
  op_e               out_op_q, out_op_d;
  err_e              out_err_q, out_err_d;
  logic [SIZE_W-1:0] out_size_q, out_size_d;
  logic [TAG_W-1:0]  out_old_q, out_old_d;
  logic [TAG_W-1:0]  out_new_q, out_new_d;
  logic              out_load, out_free;

  logic              wr_en, wr_data, rd_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_old, rd_new, old_live, new_live;

  logic              a_is_old, a_is_new, a_err3, a_oor;
  logic [AW-1:0]     a_old_addr;
  logic [SUM_W-1:0]  a_new_sum;

  atrd_ram #(
    .WIDTH (1),
    .DEPTH (TAG_COUNT),
    .ADDR_W(AW)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr0_i(a_old_addr),
    .rd_addr1_i(a_new_sum[AW-1:0]),
    .rd_data0_o(rd_old),
    .rd_data1_o(rd_new)
  );

  // Resolve tags of the head record against the last new tag.
  assign a_is_old   = (head_i.old_delta != '0);
  assign a_is_new   = (head_i.new_delta != '0);
  assign a_err3     = a_is_old && (head_i.old_delta >= DELTA_W'(lnt_q));
  assign a_old_addr = a_is_old ? (lnt_q + AW'(1) - head_i.old_delta[AW-1:0]) : '0;
  assign a_new_sum  = SUM_W'(lnt_q) + SUM_W'(head_i.new_delta);
  assign a_oor      = (a_new_sum >= SUM_W'(TAG_COUNT));

  // The pending write lands on the read edge; forward it.
  assign old_live = (byp_en_q && byp_addr_q == old_addr_q) ? byp_data_q : rd_old;
  assign new_live = (byp_en_q && byp_addr_q == new_addr_q) ? byp_data_q : rd_new;

  assign out_free = ~out_valid_q | ~out_stall_i;

  assign status_o.clearing = (state_q == BS_CLEAR);
  assign status_o.halted   = (state_q == BS_HALT);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lnt_d       = lnt_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = pend_addr_q;
    wr_data     = 1'b1;
    out_load    = 1'b0;
    out_op_d    = OP_ALLOC;
    out_err_d   = ERR_NONE;
    out_size_d  = '0;
    out_old_d   = '0;
    out_new_d   = '0;
    case (state_q)
      BS_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = 1'b0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(TAG_COUNT - 1)) begin
          state_d = BS_RUN;
        end
      end
      BS_RUN: begin
        // Finish the second write of a realloc.
        wr_en  = pend_q;
        pend_d = 1'b0;
        if (!empty_i) begin
          case (head_i.kind)
            EK_END: begin
              if (out_free) begin
                out_load = 1'b1;
                out_op_d = OP_END;
                pop_o    = 1'b1;
              end
            end
            EK_ERROR: begin
              if (out_free) begin
                out_load  = 1'b1;
                out_err_d = head_i.code;
                pop_o     = 1'b1;
                state_d   = BS_HALT;
              end
            end
            default: begin
              pop_o   = 1'b1;
              rd_en   = 1'b1;
              state_d = BS_CHECK;
            end
          endcase
        end
      end
      BS_CHECK: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = BS_HALT;
          if (err3_q) begin
            out_err_d = ERR_OLD_TOO_FAR;
          end else if (!is_new_q) begin
            if (rsize_q != '0) begin
              out_err_d = ERR_FREE_WITH_SIZE;
            end else if (!(is_old_q && old_live)) begin
              out_err_d = ERR_TAG_NOT_IN_USE;
            end else begin
              state_d   = BS_RUN;
              out_op_d  = OP_FREE;
              out_old_d = TAG_W'(old_addr_q);
              wr_en     = 1'b1;
              wr_addr   = old_addr_q;
              wr_data   = 1'b0;
            end
          end else if (is_old_q && !old_live) begin
            out_err_d = ERR_TAG_NOT_IN_USE;
          end else if (oor_q) begin
            out_err_d = ERR_TAG_OVERFLOW;
          end else if (new_live) begin
            out_err_d = ERR_TAG_IN_USE;
          end else begin
            state_d    = BS_RUN;
            out_op_d   = is_old_q ? OP_REALLOC : OP_ALLOC;
            out_size_d = rsize_q;
            out_old_d  = is_old_q ? TAG_W'(old_addr_q) : '0;
            out_new_d  = TAG_W'(new_addr_q);
            lnt_d      = new_addr_q;
            wr_en      = 1'b1;
            if (is_old_q) begin
              // Free the old tag now, set the new one next cycle.
              wr_addr     = old_addr_q;
              wr_data     = 1'b0;
              pend_d      = 1'b1;
              pend_addr_d = new_addr_q;
            end else begin
              wr_addr = new_addr_q;
            end
          end
        end
      end
      BS_HALT: begin
        // Drop everything until reset.
        pop_o = ~empty_i;
      end
      default: begin
        state_d = BS_HALT;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_CLEAR;
      clr_q       <= '0;
      lnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lnt_q       <= lnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    if (rd_en) begin
      rsize_q    <= head_i.size;
      old_addr_q <= a_old_addr;
      new_addr_q <= a_new_sum[AW-1:0];
      is_old_q   <= a_is_old;
      is_new_q   <= a_is_new;
      err3_q     <= a_err3;
      oor_q      <= a_oor;
      byp_en_q   <= wr_en;
      byp_addr_q <= wr_addr;
      byp_data_q <= wr_data;
    end
    if (out_load) begin
      out_op_q   <= out_op_d;
      out_err_q  <= out_err_d;
      out_size_q <= out_size_d;
      out_old_q  <= out_old_d;
      out_new_q  <= out_new_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign op_o        = out_op_q;
  assign error_o     = out_err_q;
  assign size_o      = out_size_q;
  assign old_tag_o   = out_old_q;
  assign new_tag_o   = out_new_q;

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_CHECK |-> !pend_q)
    else $error("realloc second write still pending at check");
  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_err_d != ERR_NONE) |=> state_q == BS_HALT)
    else $error("error result without halting");
  a_last_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    TAG_W'(lnt_q) < TAG_W'(TAG_COUNT))
    else $error("last new tag outside map");

endmodule

[rtl/alloc_trace_record_decoder.sv]
// Top level of the allocation trace record decoder.
// Depends on atrd_pkg, atrd_front, atrd_queue, atrd_back and atrd_ram.
//
// Decodes a byte stream of allocation records (size, old-tag delta, and a
// new-tag delta when size is nonzero; each number in 7-bit groups, low group
// first, top bit set on the last group) into alloc, realloc, free and end
// events, checking every tag against an in-use map held in a one-bit RAM of
// TAG_COUNT entries. The first error is reported once and the block then
// drops all input until reset. After reset the map is cleared one entry a
// cycle, all TAG_COUNT entries (65536 by default); in_stall_o stays high
// during that pass. Afterwards the front takes one byte every cycle while
// the queue is not full. The back handles a record in a tag resolve and map
// read step, then a map check, write and result step, and an end or error
// item in the first step alone; records span at least two bytes, so a
// four-entry queue between front and back keeps the input running at one
// byte per cycle while the output is not stalled. A result passes from its
// last byte through the queue into the output register, a record also
// through the check registers, and a waiting result does not block input
// until the queue fills.
module alloc_trace_record_decoder #(
  parameter int unsigned TAG_COUNT = atrd_pkg::TAG_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [atrd_pkg::BYTE_W-1:0] byte_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [atrd_pkg::OP_W-1:0]   op_o,
  output logic [atrd_pkg::ERR_W-1:0]  error_o,
  output logic [atrd_pkg::SIZE_W-1:0] size_o,
  output logic [atrd_pkg::TAG_W-1:0]  old_tag_o,
  output logic [atrd_pkg::TAG_W-1:0]  new_tag_o
);
  import atrd_pkg::*;

  // Classified items travel front -> queue -> back.
  logic         push, q_full, q_empty, pop;
  entry_t       push_entry, head;
  back_status_t status;

  // Front: parse numbers, track record fields, flag stream errors.
  atrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .byte_value_i(byte_value_i),
    .q_full_i    (q_full),
    .status_i    (status),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Queue: decouple byte-rate parsing from map work.
  atrd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (head)
  );

  // Back: resolve tags, check and update the map, drive results.
  atrd_back #(
    .TAG_COUNT(TAG_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .head_i     (head),
    .pop_o      (pop),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .op_o       (op_o),
    .error_o    (error_o),
    .size_o     (size_o),
    .old_tag_o  (old_tag_o),
    .new_tag_o  (new_tag_o)
  );

endmodule

[sim/alloc_trace_record_decoder_tb.sv]
// Self-checking testbench of the allocation trace record decoder.
// Depends on atrd_pkg and alloc_trace_record_decoder; holds its own decoder model.
module alloc_trace_record_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atrd_pkg::*;

  localparam int unsigned TAG_SPAN   = TAG_COUNT_DEF;
  // Cycles with no accepted word or taken event before the run is given up; covers the map
  // clearing pass after reset several times over.
  localparam int unsigned IDLE_LIMIT = 4 * TAG_SPAN;
  // Cycles to wait past the last expected event for stray ones.
  localparam int unsigned TAIL_WAIT  = 20;
  localparam int unsigned WORD_GOAL  = 1900;

  // One word of trace stimulus; hold asks the driver to wait until every
  // expected event has come before presenting it.
  typedef struct {
    bit         kind;
    logic [7:0] value;
    bit         hold;
  } trace_word_t;

  typedef struct packed {
    op_e               op;
    err_e              err;
    logic [SIZE_W-1:0] alloc_size;
    logic [TAG_W-1:0]  old_tag;
    logic [TAG_W-1:0]  new_tag;
  } trace_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                tr_kind = 1'b0;
  logic [BYTE_W-1:0]   tr_byte = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                ev_valid;
  logic [OP_W-1:0]     ev_op;
  logic [ERR_W-1:0]    ev_error;
  logic [SIZE_W-1:0]   ev_size;
  logic [TAG_W-1:0]    ev_old_tag;
  logic [TAG_W-1:0]    ev_new_tag;

  alloc_trace_record_decoder #(
    .TAG_COUNT(TAG_SPAN)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (tr_kind),
    .byte_value_i(tr_byte),
    .out_valid_o (ev_valid),
    .out_stall_i (out_stall),
    .op_o        (ev_op),
    .error_o     (ev_error),
    .size_o      (ev_size),
    .old_tag_o   (ev_old_tag),
    .new_tag_o   (ev_new_tag)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Decoder model: its own copy of the record state and the in-use map.
  // ---------------------------------------------------------------------
  field_pos_e         dec_pos = FP_SIZE;
  logic [1:0]         dec_groups = '0;
  logic [DELTA_W-1:0] dec_acc = '0;
  logic [SIZE_W-1:0]  dec_size = '0;
  logic [DELTA_W-1:0] dec_old_delta = '0;
  logic [TAG_W-1:0]   dec_last_tag = '0;
  bit                 dec_halted = 1'b0;
  bit                 dec_live [TAG_SPAN];

  trace_event_t expected_events[$];
  trace_word_t  trace_words[$];

  int unsigned fail_count = 0;
  int unsigned event_count = 0;

  function automatic bit tag_live(input logic [63:0] tag);
    if (tag >= TAG_SPAN) return 1'b0;
    return dec_live[tag[31:0]];
  endfunction

  task automatic push_event(input op_e op, input err_e err, input logic [SIZE_W-1:0] sz,
                            input logic [TAG_W-1:0] ot, input logic [TAG_W-1:0] nt);
    trace_event_t ev;
    ev.op = op;
    ev.err = err;
    ev.alloc_size = sz;
    ev.old_tag = ot;
    ev.new_tag = nt;
    expected_events.push_back(ev);
  endtask

  // An error event carries only its code; the decoder stops for good.
  task automatic halt_with(input err_e err);
    dec_halted = 1'b1;
    push_event(OP_ALLOC, err, '0, '0, '0);
  endtask

  // Resolve the deltas of a finished record and check them against the map.
  task automatic close_record(input logic [SIZE_W-1:0] sz, input logic [DELTA_W-1:0] od,
                              input logic [DELTA_W-1:0] nd);
    logic [TAG_W-1:0] ot;
    logic [63:0]      nt;
    ot = '0;
    nt = '0;
    dec_pos = FP_SIZE;
    if (od != 0) begin
      if (32'(od) >= dec_last_tag) begin
        halt_with(ERR_OLD_TOO_FAR);
        return;
      end
      ot = dec_last_tag + 32'd1 - 32'(od);
    end
    if (nd != 0) nt = 64'(dec_last_tag) + 64'(nd);
    if (nt == 0) begin
      if (sz != 0) begin
        halt_with(ERR_FREE_WITH_SIZE);
        return;
      end
      if (!tag_live(64'(ot))) begin
        halt_with(ERR_TAG_NOT_IN_USE);
        return;
      end
      dec_live[ot] = 1'b0;
      push_event(OP_FREE, ERR_NONE, '0, ot, '0);
      return;
    end
    // A realloc drops its old tag before the new one is looked at.
    if (ot != 0) begin
      if (!tag_live(64'(ot))) begin
        halt_with(ERR_TAG_NOT_IN_USE);
        return;
      end
      dec_live[ot] = 1'b0;
    end
    if (nt >= TAG_SPAN) begin
      halt_with(ERR_TAG_OVERFLOW);
      return;
    end
    if (tag_live(nt)) begin
      halt_with(ERR_TAG_IN_USE);
      return;
    end
    dec_live[nt[31:0]] = 1'b1;
    dec_last_tag = nt[31:0];
    push_event((ot != 0) ? OP_REALLOC : OP_ALLOC, ERR_NONE, sz, ot, nt[31:0]);
  endtask

  // Advance the model by one accepted word.
  task automatic decode_trace_byte(input logic kind, input logic [7:0] b);
    logic [DELTA_W-1:0] value;
    if (dec_halted) return;
    if (kind) begin
      if (dec_pos == FP_SIZE && dec_groups == 0) push_event(OP_END, ERR_NONE, '0, '0, '0);
      else halt_with(ERR_TRUNCATED);
      return;
    end
    dec_acc = dec_acc | (DELTA_W'(b[6:0]) << (7 * dec_groups));
    if (!b[7]) begin
      // A fourth group that does not end the number is one group too many.
      if (dec_groups == 2'd3) halt_with(ERR_UNTERMINATED);
      else dec_groups = dec_groups + 2'd1;
      return;
    end
    value = dec_acc;
    dec_acc = '0;
    dec_groups = '0;
    case (dec_pos)
      FP_OLD: begin
        if (dec_size != 0) begin
          dec_old_delta = value;
          dec_pos = FP_NEW;
        end else begin
          close_record('0, value, '0);
        end
      end
      FP_NEW: begin
        close_record(dec_size, dec_old_delta, value);
      end
      default: begin
        dec_size = value;
        dec_pos = FP_OLD;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("event %0d: %s wrong, want %0h got %0h", event_count, what, want, got);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------
  // Trace writer: builds well-formed records with its own tag bookkeeping.
  // ---------------------------------------------------------------------
  int unsigned writer_last = 0;
  int unsigned live_tags[$];
  bit          hold_next = 1'b0;

  task automatic put_byte(input bit kind, input logic [7:0] b);
    trace_word_t w;
    w.kind = kind;
    w.value = b;
    w.hold = hold_next;
    hold_next = 1'b0;
    trace_words.push_back(w);
  endtask

  task automatic put_end();
    put_byte(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Emit a number in grp groups; zero picks the shortest form, now and then
  // padded with zero groups up to four.
  task automatic put_number(input int unsigned value, input int unsigned grp);
    int unsigned n;
    n = 1;
    while (n < 4 && (value >> (7 * n)) != 0) n++;
    if (grp != 0) n = grp;
    else if ($urandom_range(0, 3) == 0) n = $urandom_range(n, 4);
    for (int unsigned i = 0; i < n; i++) begin
      put_byte(1'b0, {(i == n - 1), 7'((value >> (7 * i)) & 32'h7f)});
    end
  endtask

  function automatic int unsigned random_size();
    int unsigned w;
    int unsigned s;
    w = $urandom_range(1, SIZE_W);
    s = $urandom & ((32'd1 << w) - 1);
    return (s == 0) ? 1 : s;
  endfunction

  function automatic int unsigned random_delta();
    int unsigned r;
    int unsigned d;
    r = $urandom_range(0, 99);
    if (r < 70) d = $urandom_range(1, 4);
    else if (r < 95) d = $urandom_range(5, 64);
    else d = $urandom_range(65, 1000);
    // Keep headroom below the top of the tag space for the closing jump.
    if (writer_last + d > 60000) d = 1;
    return d;
  endfunction

  task automatic write_alloc(input int unsigned sz, input int unsigned delta,
                             input int unsigned grp);
    put_number(sz, grp);
    put_number(0, grp);
    put_number(delta, grp);
    writer_last += delta;
    // Tag one cannot be named by an old delta, so never pick it for a free.
    if (writer_last >= 2) live_tags.push_back(writer_last);
  endtask

  task automatic write_realloc(input int unsigned idx, input int unsigned sz,
                               input int unsigned delta, input int unsigned grp);
    int unsigned tag;
    tag = live_tags[idx];
    live_tags.delete(idx);
    put_number(sz, grp);
    put_number(writer_last + 1 - tag, grp);
    put_number(delta, grp);
    writer_last += delta;
    live_tags.push_back(writer_last);
  endtask

  task automatic write_free(input int unsigned idx, input int unsigned grp);
    int unsigned tag;
    tag = live_tags[idx];
    live_tags.delete(idx);
    put_number(0, grp);
    put_number(writer_last + 1 - tag, grp);
  endtask

  // Close the trace with one broken record; the decoder halts on it.
  task automatic write_fault(input int unsigned top_before);
    int unsigned pick;
    int unsigned tag;
    pick = $urandom_range(0, 5);
    case (pick)
      0: begin
        // unterminated number: four open groups, maybe after a good size
        if ($urandom_range(0, 1) != 0) put_number(random_size(), 0);
        repeat (4) put_byte(1'b0, 8'($urandom_range(0, 127)));
      end
      1: begin
        // end of stream inside a record or inside a number
        if ($urandom_range(0, 1) != 0) put_number(random_size(), 0);
        else put_byte(1'b0, 8'($urandom_range(0, 127)));
        put_end();
      end
      2: begin
        // old delta reaching past tag two
        put_number(0, 0);
        put_number(writer_last + $urandom_range(0, 100), 0);
      end
      3: begin
        // size given but no new tag
        put_number(random_size(), 0);
        put_number(0, 0);
        put_number(0, 0);
      end
      4: begin
        // new tag beyond the map, the largest delta now and then
        put_number(random_size(), 0);
        put_number(0, 0);
        if ($urandom_range(0, 1) != 0) put_number(32'h0fff_ffff, 0);
        else put_number($urandom_range(1, 1000), 0);
      end
      default: begin
        // free or realloc of a tag that is not live, or of tag zero
        tag = $urandom_range(top_before + 1, TAG_SPAN - 2);
        case ($urandom_range(0, 2))
          0: begin
            put_number(0, 0);
            put_number(0, 0);
          end
          1: begin
            put_number(0, 0);
            put_number(writer_last + 1 - tag, 0);
          end
          default: begin
            put_number(random_size(), 0);
            put_number(writer_last + 1 - tag, 0);
            put_number(1, 0);
          end
        endcase
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driver: present queued words, with random gaps and calm stretches.
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  int unsigned gap_left = 0;
  int unsigned send_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tr_kind <= 1'b0;
      tr_byte <= '0;
      gap_left <= 0;
    end else begin
      // Feed the model with the word taken at this edge.
      if (in_valid && !in_stall) decode_trace_byte(tr_kind, tr_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (trace_words.size() != 0 &&
                     !(trace_words[0].hold && expected_events.size() != 0)) begin
          tr_kind <= trace_words[0].kind;
          tr_byte <= trace_words[0].value;
          in_valid <= 1'b1;
          void'(trace_words.pop_front());
          if (send_calm != 0) begin
            send_calm <= send_calm - 1;
            gap_left <= 0;
          end else if ($urandom_range(0, 199) == 0) begin
            send_calm <= 150;
            gap_left <= 0;
          end else begin
            gap_left <= pick_pause();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: stall at random, check each taken event against the oldest
  // expected one.
  // ---------------------------------------------------------------------
  int unsigned  stall_left = 0;
  int unsigned  recv_calm = 0;
  trace_event_t due;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (ev_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected event, op", '0, 32'(ev_op));
        end else begin
          due = expected_events.pop_front();
          if (ev_op !== due.op) report_mismatch("op", 32'(due.op), 32'(ev_op));
          if (ev_error !== due.err) report_mismatch("error", 32'(due.err), 32'(ev_error));
          if (ev_size !== due.alloc_size)
            report_mismatch("size", 32'(due.alloc_size), 32'(ev_size));
          if (ev_old_tag !== due.old_tag) report_mismatch("old_tag", due.old_tag, ev_old_tag);
          if (ev_new_tag !== due.new_tag) report_mismatch("new_tag", due.new_tag, ev_new_tag);
        end
        event_count <= event_count + 1;
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (recv_calm != 0) begin
          recv_calm <= recv_calm - 1;
        end else if ($urandom_range(0, 199) == 0) begin
          recv_calm <= 150;
        end else begin
          stall_left <= pick_pause();
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: give up when no word moves on either side for too long.
  // ---------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (ev_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int unsigned r;
    int unsigned top_before;

    // Directed opening: end before any record, largest size, padded
    // numbers with zero groups, a realloc and a free, end between records.
    put_end();
    write_alloc(32'h0fff_ffff, 1, 0);
    write_alloc(1, 1, 4);
    write_realloc(0, 5, 1, 1);
    write_free(live_tags.size() - 1, 4);
    put_end();
    write_alloc(random_size(), 2, 0);

    // Random part: mostly good records with random content; hold once at
    // the start so the opening drains completely.
    hold_next = 1'b1;
    while (trace_words.size() < WORD_GOAL) begin
      r = $urandom_range(0, 99);
      if (r < 8) put_end();
      else if (r < 45 || live_tags.size() == 0) write_alloc(random_size(), random_delta(), 0);
      else if (r < 70)
        write_realloc($urandom_range(0, live_tags.size() - 1), random_size(),
                      random_delta(), 0);
      else write_free($urandom_range(0, live_tags.size() - 1), 0);
      if ($urandom_range(0, 99) == 0) hold_next = 1'b1;
    end

    // Jump to the top tag, drop one live tag, then break the trace and
    // check that the halted decoder stays silent.
    top_before = writer_last;
    hold_next = 1'b1;
    write_alloc(random_size(), TAG_SPAN - 1 - writer_last, 0);
    if (live_tags.size() > 1) write_free($urandom_range(0, live_tags.size() - 2), 0);
    hold_next = 1'b1;
    write_fault(top_before);
    repeat (6) put_byte(1'(($urandom_range(0, 3) == 0)), 8'($urandom_range(0, 255)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to go in and every expected event to come out.
    do @(posedge clk_i);
    while (trace_words.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
